>>> hw/rtl/binary_threshold_xnor_dot_product_unit_macros.svh
// assertion macros used by the checker file
`ifndef BINARY_THRESHOLD_XNOR_DOT_PRODUCT_UNIT_MACROS_SVH
`define BINARY_THRESHOLD_XNOR_DOT_PRODUCT_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BXDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: label");

// next-cycle implication, disabled while reset is asserted
`define BXDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: label");

`endif

>>> hw/rtl/bxdp_pkg.sv
// shared types and constants of the binary threshold xnor dot product unit
`default_nettype none

package bxdp_pkg;

    localparam int MAX_LANES  = 8;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 4;
    localparam int SUM_W      = 16;
    localparam int SCALE_W    = 16;
    localparam int SHIFT_W    = 32;
    localparam int PROD_W     = 32;
    localparam int VALUE_W    = 34;
    localparam int FRAC_BITS  = 12;

    // slave tdata layout
    localparam int ACT_LSB    = 0;
    localparam int NB_LSB     = ACT_LSB + MAX_LANES * BYTE_W;
    localparam int WGT_LSB    = NB_LSB + MAX_LANES * BYTE_W;
    localparam int CNT_LSB    = WGT_LSB + MAX_LANES;
    localparam int SCALE_LSB  = CNT_LSB + CNT_W;
    localparam int SHIFT_LSB  = SCALE_LSB + SCALE_W;
    localparam int S_FIELDS_W = SHIFT_LSB + SHIFT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // master tdata layout
    localparam int VALUE_LSB  = 0;
    localparam int RAW_LSB    = VALUE_LSB + VALUE_W;
    localparam int M_FIELDS_W = RAW_LSB + SUM_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELU_ENABLE  = 2'd1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 16'sh7FFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 16'sh8000;

    typedef struct packed {
        logic scale_en;
        logic relu_en;
    } bxdp_cfg_t;

    // finished sum handed to the scaling pipeline
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [SCALE_W-1:0] scale;
        logic [SHIFT_W-1:0] shift;
    } bxdp_job_t;

endpackage

`default_nettype wire

>>> hw/rtl/bxdp_lane_cell.sv
// one lane cell: registered xnor vote and a saturating +-1 step on the passing sum
`default_nettype none

module bxdp_lane_cell (
    input  wire logic                          clk,
    input  wire logic                          load,
    input  wire logic [bxdp_pkg::BYTE_W-1:0]   act,
    input  wire logic [bxdp_pkg::BYTE_W-1:0]   neg_bias,
    input  wire logic                          weight,
    input  wire logic                          lane_en,
    input  wire logic [bxdp_pkg::SUM_W-1:0]    sum_in,
    output logic      [bxdp_pkg::SUM_W-1:0]    sum_out
);
    import bxdp_pkg::*;

    logic vote_reg;
    logic vote_next;
    logic en_reg;

    // threshold bit xor weight sign
    assign vote_next = ($signed(neg_bias) > $signed(act)) ^ weight;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vote_reg <= vote_next;
            en_reg   <= lane_en;
        end
    end

    always_comb
    begin
        sum_out = sum_in;
        if (en_reg)
        begin
            if (vote_reg)
            begin
                if ($signed(sum_in) != SUM_MAX)
                begin
                    sum_out = sum_in + 16'd1;
                end
            end
            else
            begin
                if ($signed(sum_in) != SUM_MIN)
                begin
                    sum_out = sum_in - 16'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bxdp_scale_pipe.sv
// scale, shift and clamp pipeline for finished sums, with output register
`default_nettype none

module bxdp_scale_pipe (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bxdp_pkg::bxdp_cfg_t           cfg,
    input  wire logic                          job_valid,
    output logic                               job_ready,
    input  wire bxdp_pkg::bxdp_job_t           job,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [bxdp_pkg::VALUE_W-1:0]  value,
    output logic      [bxdp_pkg::SUM_W-1:0]    raw_sum
);
    import bxdp_pkg::*;

    logic                 c_valid_reg;
    bxdp_job_t            c_job_reg;

    logic                 d_valid_reg;
    logic [PROD_W-1:0]    d_prod_reg;
    logic [PROD_W-1:0]    d_prod_next;
    logic [SHIFT_W-1:0]   d_add_reg;
    logic [SHIFT_W-1:0]   d_add_next;
    logic [SUM_W-1:0]     d_sum_reg;

    logic                 e_valid_reg;
    logic [VALUE_W-1:0]   e_value_reg;
    logic [VALUE_W-1:0]   e_value_next;
    logic [VALUE_W-1:0]   e_sum34;
    logic [SUM_W-1:0]     e_sum_reg;

    logic                 d_ready;
    logic                 e_ready;
    logic                 c_load;
    logic                 d_load;
    logic                 e_load;

    assign e_ready   = !e_valid_reg || out_ready;
    assign d_ready   = !d_valid_reg || e_ready;
    assign job_ready = !c_valid_reg || d_ready;

    assign c_load = job_valid && job_ready;
    assign d_load = c_valid_reg && d_ready;
    assign e_load = d_valid_reg && e_ready;

    // multiply stage; with scaling off the sum is only shifted up by FRAC_BITS
    always_comb
    begin
        if (cfg.scale_en)
        begin
            d_prod_next = PROD_W'($signed(c_job_reg.sum) * $signed(c_job_reg.scale));
            d_add_next  = c_job_reg.shift;
        end
        else
        begin
            d_prod_next = {{(PROD_W-SUM_W-FRAC_BITS){c_job_reg.sum[SUM_W-1]}},
                           c_job_reg.sum, {FRAC_BITS{1'b0}}};
            d_add_next  = '0;
        end
    end

    // shift add and clamp stage
    always_comb
    begin
        e_sum34 = {{(VALUE_W-PROD_W){d_prod_reg[PROD_W-1]}}, d_prod_reg}
                + {{(VALUE_W-SHIFT_W){d_add_reg[SHIFT_W-1]}}, d_add_reg};
        e_value_next = e_sum34;
        if (cfg.relu_en && e_sum34[VALUE_W-1])
        begin
            e_value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
            begin
                c_valid_reg <= job_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_job_reg <= job;
        end
        if (d_load)
        begin
            d_prod_reg <= d_prod_next;
            d_add_reg  <= d_add_next;
            d_sum_reg  <= c_job_reg.sum;
        end
        if (e_load)
        begin
            e_value_reg <= e_value_next;
            e_sum_reg   <= d_sum_reg;
        end
    end

    assign out_valid = e_valid_reg;
    assign value     = e_value_reg;
    assign raw_sum   = e_sum_reg;

endmodule

`default_nettype wire

>>> hw/rtl/binary_threshold_xnor_dot_product_unit.sv
// top level of the binary threshold xnor dot product unit
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tdata lane data + scale/shift, s_tlast
//  m_*     | out       | m_tvalid/m_tready  | m_tdata value_q12, raw_sum
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one input transfer per cycle sustained, except while a last item waits for the
// scaling pipeline; the lane cells form a combinational chain that applies up to
// eight saturating +-1 steps to the running sum
// after the item with s_tlast transfers, its result passes the vote register, the
// job register, the product register and the output register before m_tvalid rises
// items without s_tlast keep flowing while a result waits on m_tready; a last item
// waits only when the scaling pipeline is full
// rst_n clears the sum, the configuration and all valid flags; cfg_ready is always high
`default_nettype none

module binary_threshold_xnor_dot_product_unit #(
    parameter int LANES = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // slave stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // act_bytes[63:0], neg_bias_bytes[127:64], weight_bits[135:128],
    // lane_count[139:136], scale_q12[155:140], shift_q12[187:156], zero fill
    input  wire logic [bxdp_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tlast,
    // master stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // value_q12[33:0], raw_sum[49:34], zero fill
    output logic      [bxdp_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bxdp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic                               cfg_data
);
    import bxdp_pkg::*;

    // configuration registers
    logic       scale_en_reg;
    logic       relu_en_reg;
    bxdp_cfg_t  cfg;

    // vote stage (lane votes live inside the cells)
    logic                a_valid_reg;
    logic                a_last_reg;
    logic [SCALE_W-1:0]  a_scale_reg;
    logic [SHIFT_W-1:0]  a_shift_reg;

    // running sum
    logic [SUM_W-1:0]    acc_reg;
    logic [SUM_W-1:0]    acc_next;
    logic [SUM_W-1:0]    chain [LANES+1];

    logic                in_xfer;
    logic                a_drain;
    logic                job_valid;
    logic                job_ready;
    bxdp_job_t           job;
    logic [CNT_W-1:0]    lane_cnt;

    logic [VALUE_W-1:0]  out_value;
    logic [SUM_W-1:0]    out_raw;

    assign cfg_ready = 1'b1;
    assign cfg.scale_en = scale_en_reg;
    assign cfg.relu_en  = relu_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_en_reg <= 1'b0;
            relu_en_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCALE_ENABLE: scale_en_reg <= cfg_data;
                CFG_RELU_ENABLE:  relu_en_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // a last item leaves the vote stage only into a free scaling slot
    assign job_valid = a_valid_reg && a_last_reg;
    assign a_drain   = a_valid_reg && (!a_last_reg || job_ready);
    assign s_tready  = !a_valid_reg || a_drain;
    assign in_xfer   = s_tvalid && s_tready;
    assign lane_cnt  = s_tdata[CNT_LSB +: CNT_W];

    // chain of lane cells, lane 0 first
    assign chain[0] = acc_reg;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        bxdp_lane_cell u_cell (
            .clk      (clk),
            .load     (in_xfer),
            .act      (s_tdata[ACT_LSB + k*BYTE_W +: BYTE_W]),
            .neg_bias (s_tdata[NB_LSB + k*BYTE_W +: BYTE_W]),
            .weight   (s_tdata[WGT_LSB + k]),
            .lane_en  (lane_cnt > CNT_W'(k)),
            .sum_in   (chain[k]),
            .sum_out  (chain[k+1])
        );
    end

    // sum clears after the last item of a neuron
    always_comb
    begin
        acc_next = acc_reg;
        if (a_drain)
        begin
            acc_next = a_last_reg ? '0 : chain[LANES];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (in_xfer)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_drain)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_last_reg  <= s_tlast;
            a_scale_reg <= s_tdata[SCALE_LSB +: SCALE_W];
            a_shift_reg <= s_tdata[SHIFT_LSB +: SHIFT_W];
        end
    end

    assign job.sum   = chain[LANES];
    assign job.scale = a_scale_reg;
    assign job.shift = a_shift_reg;

    bxdp_scale_pipe u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .value     (out_value),
        .raw_sum   (out_raw)
    );

    assign m_tdata = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, out_raw, out_value};

endmodule

`default_nettype wire

>>> hw/rtl/bxdp_checker.sv
// port-level checker for the dot product unit, bound to the top level
`default_nettype none

`include "binary_threshold_xnor_dot_product_unit_macros.svh"

module bxdp_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [bxdp_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic [bxdp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic                               cfg_data
);
    import bxdp_pkg::*;

    logic                scale_sh_reg;
    logic                relu_sh_reg;
    logic [VALUE_W-1:0]  value;
    logic [SUM_W-1:0]    raw;
    logic [VALUE_W-1:0]  raw_shifted;
    logic                plain_case;

    assign value       = m_tdata[VALUE_LSB +: VALUE_W];
    assign raw         = m_tdata[RAW_LSB +: SUM_W];
    assign raw_shifted = {{(VALUE_W-SUM_W-FRAC_BITS){raw[SUM_W-1]}}, raw, {FRAC_BITS{1'b0}}};
    // unscaled result that the clamp leaves alone
    assign plain_case  = m_tvalid && !scale_sh_reg && (!relu_sh_reg || !raw[SUM_W-1]);

    // shadow of the configuration as seen on the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_sh_reg <= 1'b0;
            relu_sh_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCALE_ENABLE: scale_sh_reg <= cfg_data;
                CFG_RELU_ENABLE:  relu_sh_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    `BXDP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `BXDP_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `BXDP_ASSERT_NOW(a_plain_shift, clk, rst_n, plain_case, value == raw_shifted)
    `BXDP_ASSERT_NOW(a_relu_clamp, clk, rst_n, m_tvalid && relu_sh_reg, !value[VALUE_W-1])

endmodule

bind binary_threshold_xnor_dot_product_unit bxdp_checker u_bxdp_checker (.*);

`default_nettype wire
